>>> rtl/core/rnf_pkg.sv
// Shared types and constants for the radix number formatter.
// No dependencies; imported by every rnf_* module and the top level.
`default_nettype none

package rnf_pkg;

  // Register map of the configuration port
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_RADIX      = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_CHARS_LOW  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_CHARS_HIGH = 2'd2;

  localparam int unsigned CfgDataW = 64;
  localparam int unsigned RadixW   = 5;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned UnsW     = 32;   // unsigned mode uses the low word only
  localparam int unsigned PtrW     = 64;
  localparam int unsigned CharW    = 8;

  localparam logic [RadixW-1:0]   RadixRst     = 5'd10;
  localparam logic [CfgDataW-1:0] CharsLowRst  = 64'h3736_3534_3332_3130;  // "01234567"
  localparam logic [CfgDataW-1:0] CharsHighRst = 64'h6665_6463_6261_3938;  // "89abcdef"

  localparam int unsigned MaxDigitsDef    = 32;
  localparam int unsigned AlphabetSizeDef = 16;

  // Command to the bit-serial divider
  typedef struct packed {
    logic              load;   // take a new dividend
    logic              next;   // divide the held quotient again
    logic [RadixW-1:0] base;
    logic [UnsW-1:0]   value;
  } rnf_div_cmd_t;

  // Status from the bit-serial divider
  typedef struct packed {
    logic              busy;
    logic              done;   // one-cycle pulse, digit and qzero valid
    logic [DigitW-1:0] digit;
    logic              qzero;
  } rnf_div_res_t;

endpackage

`default_nettype wire

>>> rtl/core/radix_number_formatter.sv
// Radix number formatter, top level: control sequencer, config regs, output word register.
// Depends on rnf_pkg, rnf_div_serial, rnf_digit_buf.
// Unsigned mode: each digit is a 32-bit serial divide plus writeback; each char is then
//   read from the digit store and emitted. Pointer mode: find the top nonzero nibble,
//   then 1 word per cycle. "(nil)": 5 words, 1 per cycle. Both rates hold unless stalled.
// Next word accepted once the last char sits in the output reg.
// Reset (async, active low) clears control and restores radix 10 and alphabet "0..9a..f".
`default_nettype none

module radix_number_formatter #(
  parameter int unsigned MAX_DIGITS    = rnf_pkg::MaxDigitsDef,
  parameter int unsigned ALPHABET_SIZE = rnf_pkg::AlphabetSizeDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // config write port
  input  wire logic                          cfg_we_i,
  input  wire logic [rnf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [rnf_pkg::CfgDataW-1:0]  cfg_data_i,
  // request stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [rnf_pkg::PtrW-1:0]      s_axis_tdata,   // [63:0] number_value
  input  wire logic                          s_axis_tuser,   // [0] req_type
  // character stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [rnf_pkg::CharW-1:0]          m_axis_tdata,   // [7:0] out_char
  output logic                               m_axis_tlast    // last_char
);
  import rnf_pkg::*;

  localparam int unsigned AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned CW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned NibW = 5;                 // counts 0..16 hex digits
  localparam logic [NibW-1:0] PtrNibbles = 5'd16;
  localparam logic [RadixW-1:0] AlphaMax = RadixW'(ALPHABET_SIZE);
  localparam logic [RadixW-1:0] RadixMin = 5'd2;

  localparam logic [CharW-1:0] HexLower [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };
  localparam logic [CharW-1:0] NilText [5] = '{8'h28, 8'h6e, 8'h69, 8'h6c, 8'h29};
  localparam logic [2:0]       NilLast     = 3'd4;
  localparam logic [CharW-1:0] ChZero      = 8'h30;
  localparam logic [CharW-1:0] ChX         = 8'h78;

  typedef enum logic [3:0] {
    S_IDLE, S_NIL, S_SKIP, S_PFX0, S_PFXX, S_HEX, S_DIV, S_RD, S_EMIT
  } state_e;

  state_e state_q;

  // config registers
  logic [RadixW-1:0]   radix_q;
  logic [CfgDataW-1:0] chars_low_q, chars_high_q;

  // sequencer state
  logic [CW-1:0]       n_q;        // digits stored so far
  logic [AW-1:0]       idx_q;      // readout position, MSD first
  logic [2:0]          nil_idx_q;
  logic [PtrW-1:0]     hex_q;      // pointer value, shifted left a nibble at a time
  logic [NibW-1:0]     nib_q;      // hex digits left

  logic [CharW-1:0]    out_data_q;
  logic                out_valid_q, out_last_q;

  rnf_div_cmd_t        div_cmd;
  rnf_div_res_t        div_res;
  logic [RadixW-1:0]   base;
  logic                out_free, in_acc, div_stop, buf_we, buf_re;
  logic                load_word;
  logic [DigitW-1:0]   buf_rdata;
  logic [2*CfgDataW-1:0] alpha;
  logic [CharW-1:0]    alpha_char;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q      <= RadixRst;
      chars_low_q  <= CharsLowRst;
      chars_high_q <= CharsHighRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RADIX:      radix_q      <= cfg_data_i[RadixW-1:0];
        REG_CHARS_LOW:  chars_low_q  <= cfg_data_i;
        REG_CHARS_HIGH: chars_high_q <= cfg_data_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // effective base: clamp into 2..ALPHABET_SIZE
  always_comb begin
    if (radix_q < RadixMin) begin
      base = RadixMin;
    end else if (radix_q > AlphaMax) begin
      base = AlphaMax;
    end else begin
      base = radix_q;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // a new word enters the output register in every emitting state with room for it
  assign load_word = out_free && (state_q == S_NIL  || state_q == S_PFX0 ||
                                  state_q == S_PFXX || state_q == S_HEX  ||
                                  state_q == S_EMIT);

  // stop dividing on a zero quotient or when the digit store is full
  assign div_stop = div_res.qzero || (n_q == CW'(MAX_DIGITS - 1));

  always_comb begin
    div_cmd.load  = in_acc && !s_axis_tuser;
    div_cmd.next  = (state_q == S_DIV) && div_res.done && !div_stop;
    div_cmd.base  = base;
    div_cmd.value = s_axis_tdata[UnsW-1:0];
  end

  assign buf_we = (state_q == S_DIV) && div_res.done;
  assign buf_re = (state_q == S_RD);

  assign alpha      = {chars_high_q, chars_low_q};
  assign alpha_char = alpha[{buf_rdata, 3'b000} +: CharW];

  rnf_div_serial u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .res_o  (div_res)
  );

  rnf_digit_buf #(
    .DEPTH (MAX_DIGITS)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (n_q[AW-1:0]),
    .wdata_i (div_res.digit),
    .re_i    (buf_re),
    .raddr_i (idx_q),
    .rdata_o (buf_rdata)
  );

  // Sequencer and output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      idx_q       <= '0;
      nil_idx_q   <= '0;
      hex_q       <= '0;
      nib_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      out_valid_q <= load_word || (out_valid_q && !m_axis_tready);
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser) begin
              if (s_axis_tdata == '0) begin
                nil_idx_q <= '0;
                state_q   <= S_NIL;
              end else begin
                hex_q   <= s_axis_tdata;
                nib_q   <= PtrNibbles;
                state_q <= S_SKIP;
              end
            end else begin
              n_q     <= '0;
              state_q <= S_DIV;
            end
          end
        end
        S_NIL: begin
          if (out_free) begin
            out_data_q  <= NilText[nil_idx_q];
            out_last_q  <= (nil_idx_q == NilLast);
            nil_idx_q   <= nil_idx_q + 1'b1;
            if (nil_idx_q == NilLast) begin
              state_q <= S_IDLE;
            end
          end
        end
        S_SKIP: begin
          // value is nonzero, so a nonzero top nibble turns up within 15 shifts
          if (hex_q[PtrW-1 -: DigitW] == '0) begin
            hex_q <= {hex_q[PtrW-DigitW-1:0], {DigitW{1'b0}}};
            nib_q <= nib_q - 1'b1;
          end else begin
            state_q <= S_PFX0;
          end
        end
        S_PFX0: begin
          if (out_free) begin
            out_data_q  <= ChZero;
            out_last_q  <= 1'b0;
            state_q     <= S_PFXX;
          end
        end
        S_PFXX: begin
          if (out_free) begin
            out_data_q  <= ChX;
            out_last_q  <= 1'b0;
            state_q     <= S_HEX;
          end
        end
        S_HEX: begin
          if (out_free) begin
            out_data_q  <= HexLower[hex_q[PtrW-1 -: DigitW]];
            out_last_q  <= (nib_q == NibW'(1));
            hex_q       <= {hex_q[PtrW-DigitW-1:0], {DigitW{1'b0}}};
            nib_q       <= nib_q - 1'b1;
            if (nib_q == NibW'(1)) begin
              state_q <= S_IDLE;
            end
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            n_q <= n_q + 1'b1;
            if (div_stop) begin
              idx_q   <= n_q[AW-1:0];   // most significant digit
              state_q <= S_RD;
            end
          end
        end
        S_RD: begin
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_data_q  <= alpha_char;
            out_last_q  <= (idx_q == '0);
            if (idx_q == '0) begin
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_q - 1'b1;
              state_q <= S_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // divider is never left running once the sequencer is back at idle
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !div_res.busy)
    else $error("divider busy while sequencer idle");

  // digit writes stay inside the store
  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_we |-> (n_q < CW'(MAX_DIGITS)))
    else $error("digit write past end of store");

  // hex emission never runs with an empty digit count
  a_hex_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HEX || state_q == S_SKIP) |-> (nib_q != '0))
    else $error("hex digit count exhausted");

  // the word register is never overwritten while a stalled word waits
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("pending output word lost");

endmodule

`default_nettype wire

>>> rtl/core/rnf_div_serial.sv
// Bit-serial restoring divider: one dividend bit per cycle, one digit per pass.
// Depends on rnf_pkg.
`default_nettype none

module rnf_div_serial (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire rnf_pkg::rnf_div_cmd_t cmd_i,
  output rnf_pkg::rnf_div_res_t      res_o
);
  import rnf_pkg::*;

  localparam int unsigned CntW = $clog2(UnsW);

  logic [UnsW-1:0]   quot_q;
  logic [DigitW-1:0] rem_q;
  logic [CntW-1:0]   cnt_q;
  logic              busy_q, done_q;
  logic [RadixW-1:0] base_q;

  logic [RadixW-1:0] shifted;
  logic              ge;

  // rem < base <= 16, so the shifted partial remainder fits in five bits
  assign shifted = {rem_q, quot_q[UnsW-1]};
  assign ge      = (shifted >= base_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.load || cmd_i.next) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(UnsW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      quot_q <= cmd_i.value;
      base_q <= cmd_i.base;
      rem_q  <= '0;
    end else if (cmd_i.next) begin
      rem_q <= '0;
    end else if (busy_q) begin
      quot_q <= {quot_q[UnsW-2:0], ge};
      rem_q  <= ge ? DigitW'(shifted - base_q) : shifted[DigitW-1:0];
    end
  end

  assign res_o.busy  = busy_q;
  assign res_o.done  = done_q;
  assign res_o.digit = rem_q;
  assign res_o.qzero = (quot_q == '0);

endmodule

`default_nettype wire

>>> rtl/core/rnf_digit_buf.sv
// Digit store: one write port, one registered read port.
// Depends on rnf_pkg.
`default_nettype none

module rnf_digit_buf #(
  parameter int unsigned DEPTH = rnf_pkg::MaxDigitsDef,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [AW-1:0]             waddr_i,
  input  wire logic [rnf_pkg::DigitW-1:0] wdata_i,
  input  wire logic                      re_i,
  input  wire logic [AW-1:0]             raddr_i,
  output logic [rnf_pkg::DigitW-1:0]     rdata_o
);
  import rnf_pkg::*;

  logic [DigitW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for radix_number_formatter: directed and random requests in
// unsigned and pointer mode, every character word checked in order against a local predictor.
// Depends on rnf_pkg and the radix_number_formatter RTL only.

module testbench;
  import rnf_pkg::*;

  // Worst case is radix 2 on 32 digits plus a heavily stalled readout;
  // ~160 requests of that kind stay well below this bound.
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  // Quiet window after the last expected character, to catch stray words.
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned DIGIT_SLOTS   = 32;
  localparam int unsigned NIL_LEN       = 5;

  // Index 3 is not mapped; writes to it must leave every register alone.
  localparam logic [CfgIdxW-1:0] REG_UNMAPPED = 2'd3;

  // Request kinds carried on s_axis_tuser
  localparam bit REQ_UNSIGNED = 1'b0;
  localparam bit REQ_POINTER  = 1'b1;

  localparam logic [CharW-1:0] ASCII_ZERO = 8'h30;  // '0'
  localparam logic [CharW-1:0] ASCII_A    = 8'h61;  // 'a'
  localparam logic [CharW-1:0] ASCII_X    = 8'h78;  // 'x'

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
  } text_char_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i     = '0;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [PtrW-1:0]      s_axis_tdata  = '0;   // [63:0] number_value
  logic                 s_axis_tuser  = 1'b0; // [0] req_type
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [CharW-1:0]     m_axis_tdata;         // [7:0] out_char
  logic                 m_axis_tlast;         // last_char

  // Local copy of the configuration registers
  logic [RadixW-1:0]    radix_reg;
  logic [CfgDataW-1:0]  chars_low_reg;
  logic [CfgDataW-1:0]  chars_high_reg;

  // Characters still owed by the block, oldest first
  text_char_t           pending_chars[$];

  int unsigned          sender_idle_pct   = 0;
  int unsigned          receiver_idle_pct = 0;
  int unsigned          cycle_count       = 0;
  bit                   failed            = 1'b0;

  radix_number_formatter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Register values 0/1 fold to base 2, anything above 16 to base 16.
  function automatic int unsigned active_radix();
    int unsigned r;
    r = radix_reg;
    if (r < 2) r = 2;
    if (r > 16) r = 16;
    return r;
  endfunction

  function automatic logic [CharW-1:0] alphabet_char(logic [DigitW-1:0] d);
    if (d < 8) return chars_low_reg[8*d +: 8];
    return chars_high_reg[8*(d-8) +: 8];
  endfunction

  // Works out the text for one request and queues it, one entry per character.
  function automatic void format_request(bit ptr, logic [PtrW-1:0] value);
    logic [DigitW-1:0] digits[DIGIT_SLOTS];
    logic [PtrW-1:0]   rest;
    logic [PtrW-1:0]   base;
    int unsigned       n;
    string             nil_text;
    text_char_t        c;
    nil_text = "(nil)";
    // Null pointer: fixed text, no digit conversion at all
    if (ptr && value == '0) begin
      for (int i = 0; i < NIL_LEN; i++) begin
        c.ch   = nil_text[i];
        c.last = (i == NIL_LEN - 1);
        pending_chars.push_back(c);
      end
      return;
    end
    if (ptr) begin
      base = 64'd16;
      rest = value;
    end else begin
      base = 64'(active_radix());
      rest = {32'd0, value[UnsW-1:0]};
    end
    // Least significant digit first; a zero value still yields one digit
    n = 0;
    do begin
      digits[n] = DigitW'(rest % base);
      rest      = rest / base;
      n++;
    end while (rest != '0 && n < DIGIT_SLOTS);
    if (ptr) begin
      c.last = 1'b0;
      c.ch   = ASCII_ZERO;
      pending_chars.push_back(c);
      c.ch   = ASCII_X;
      pending_chars.push_back(c);
    end
    while (n > 0) begin
      n--;
      if (!ptr) c.ch = alphabet_char(digits[n]);
      else if (digits[n] < 10) c.ch = ASCII_ZERO + CharW'(digits[n]);
      else c.ch = ASCII_A + CharW'(digits[n]) - 8'd10;
      c.last = (n == 0);
      pending_chars.push_back(c);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driving side
  // ---------------------------------------------------------------------------

  // Receiver backpressure, redrawn every cycle
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Sends one request word. tvalid is left high after the handshake: the next call
  // either replaces the word or drops tvalid at the very next falling edge.
  task automatic send_request(bit ptr, logic [PtrW-1:0] value);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= ptr;
    do @(posedge clk_i); while (!s_axis_tready);
    format_request(ptr, value);
  endtask

  // Drops tvalid and holds off until every owed character has come out.
  task automatic wait_until_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
  endtask

  // Only called with the block drained, so the local copy updates at once.
  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_RADIX:      radix_reg      = data[RadixW-1:0];
      REG_CHARS_LOW:  chars_low_reg  = data;
      REG_CHARS_HIGH: chars_high_reg = data;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Checking side
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected word: out_char %h last_char %b", m_axis_tdata, m_axis_tlast);
        failed = 1'b1;
      end else begin
        want = pending_chars.pop_front();
        if (m_axis_tdata !== want.ch) begin
          $error("out_char: expected %h, got %h", want.ch, m_axis_tdata);
          failed = 1'b1;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_char: expected %b, got %b", want.last, m_axis_tlast);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("radix_number_formatter: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset configuration: decimal, stock alphabet; pointer extremes and null
  task automatic test_default_format();
    send_request(REQ_UNSIGNED, 64'd0);
    send_request(REQ_UNSIGNED, 64'h0000_0000_FFFF_FFFF);
    send_request(REQ_UNSIGNED, 64'hFFFF_FFFF_0000_0000);  // upper word ignored
    send_request(REQ_UNSIGNED, 64'h1234_5678_0000_002A);
    send_request(REQ_POINTER,  64'd0);
    send_request(REQ_POINTER,  64'd1);
    send_request(REQ_POINTER,  '1);
    send_request(REQ_POINTER,  64'h8000_0000_0000_0000);
    send_request(REQ_POINTER,  64'h0000_0000_DEAD_BEEF);
    wait_until_drained();
  endtask

  // Base extremes, plus register values below 2 and above 16 that get clamped
  task automatic test_radix_limits();
    logic [CfgDataW-1:0] radix_words[8] = '{
      64'd2, 64'd16, 64'd0, 64'd1, 64'd31, 64'd17, 64'd3,
      64'hFFFF_FFFF_FFFF_FFE7  // only the low five bits count: base 7
    };
    logic [PtrW-1:0] values[8] = '{
      64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'd5, 64'd6, 64'hFEDC_BA98, 64'd255,
      64'hFFFF_FFFF, 64'h8000_0000
    };
    for (int i = 0; i < 8; i++) begin
      cfg_write(REG_RADIX, radix_words[i]);
      send_request(REQ_UNSIGNED, values[i]);
      wait_until_drained();
    end
  endtask

  // Odd alphabet with zero and high bytes; pointer mode must ignore it;
  // an unmapped register write changes nothing
  task automatic test_alphabet();
    cfg_write(REG_RADIX,      64'd16);
    cfg_write(REG_CHARS_LOW,  64'h00FF_7F80_0102_FE00);
    cfg_write(REG_CHARS_HIGH, 64'hA55A_00FF_C33C_0180);
    send_request(REQ_UNSIGNED, 64'h0123_4567);
    send_request(REQ_UNSIGNED, 64'h89AB_CDEF);
    send_request(REQ_UNSIGNED, 64'd0);
    send_request(REQ_POINTER,  64'hABC);
    wait_until_drained();
    cfg_write(REG_UNMAPPED, '1);
    send_request(REQ_UNSIGNED, 64'hFEDC_BA98);
    wait_until_drained();
  endtask

  function automatic logic [RadixW-1:0] pick_radix();
    case ($urandom_range(9))
      0:       return RadixW'($urandom_range(1));
      1:       return RadixW'($urandom_range(31, 17));
      default: return RadixW'($urandom_range(16, 2));
    endcase
  endfunction

  function automatic logic [PtrW-1:0] pick_value();
    case ($urandom_range(5))
      0:       return 64'($urandom_range(40));
      1:       return '0;
      2:       return 64'd1 << $urandom_range(63);
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Random requests; the configuration is reshuffled every so often with the block
  // drained, which also stalls the sender until all owed characters are out.
  task automatic test_random_stream(int unsigned send_pct, int unsigned recv_pct,
                                    int unsigned count);
    logic [CfgDataW-1:0] word;
    sender_idle_pct   = send_pct;
    receiver_idle_pct = recv_pct;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 18 == 0) begin
        wait_until_drained();
        word         = {$urandom(), $urandom()};
        word[RadixW-1:0] = pick_radix();
        cfg_write(REG_RADIX, word);
        if ($urandom_range(1)) cfg_write(REG_CHARS_LOW,  {$urandom(), $urandom()});
        if ($urandom_range(1)) cfg_write(REG_CHARS_HIGH, {$urandom(), $urandom()});
        if ($urandom_range(3) == 0) cfg_write(REG_UNMAPPED, {$urandom(), $urandom()});
      end
      send_request(($urandom_range(3) == 0) ? REQ_POINTER : REQ_UNSIGNED, pick_value());
    end
    wait_until_drained();
  endtask

  initial begin
    radix_reg      = RadixRst;
    chars_low_reg  = CharsLowRst;
    chars_high_reg = CharsHighRst;
    sender_idle_pct   = 35;
    receiver_idle_pct = 79;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_default_format();
    test_radix_limits();
    test_alphabet();
    test_random_stream(35, 79, 46);
    test_random_stream(79, 35, 46);
    test_random_stream(0, 0, 46);

    // Anything still coming out now would be a stray word
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (!failed && pending_chars.size() == 0) begin
      $display("radix_number_formatter: match");
    end else begin
      $display("radix_number_formatter: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/rnf_pkg.sv
rtl/core/rnf_div_serial.sv
rtl/core/rnf_digit_buf.sv
rtl/core/radix_number_formatter.sv
tb/sv/testbench.sv
